@@ design/drpu_pkg.sv @@
// Shared constants, arctangent table and register codes for the pose update core.
`timescale 1ns / 1ps
package drpu_pkg;

	localparam int MAX_STEPS = 30;
	localparam int STEP_W = 5;

	localparam logic [0:0] REG_MAP_WIDTH  = 1'b0;
	localparam logic [0:0] REG_MAP_HEIGHT = 1'b1;

	localparam logic [21:0] TWO_PI_Q16 = 22'd411775;
	localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [63:0] ROUND_Q30   = 64'sd536870912;

	function automatic logic signed [35:0] atan_q30(input logic [STEP_W-1:0] idx);
		logic signed [35:0] v;
		begin
			case (idx)
				5'd0:  v = 36'sd843314857;
				5'd1:  v = 36'sd497837829;
				5'd2:  v = 36'sd263043836;
				5'd3:  v = 36'sd133525158;
				5'd4:  v = 36'sd67021686;
				5'd5:  v = 36'sd33543515;
				5'd6:  v = 36'sd16775850;
				5'd7:  v = 36'sd8388437;
				5'd8:  v = 36'sd4194282;
				5'd9:  v = 36'sd2097149;
				5'd10: v = 36'sd1048575;
				5'd11: v = 36'sd524287;
				5'd12: v = 36'sd262143;
				5'd13: v = 36'sd131071;
				5'd14: v = 36'sd65535;
				5'd15: v = 36'sd32767;
				5'd16: v = 36'sd16383;
				5'd17: v = 36'sd8191;
				5'd18: v = 36'sd4095;
				5'd19: v = 36'sd2047;
				5'd20: v = 36'sd1023;
				5'd21: v = 36'sd511;
				5'd22: v = 36'sd255;
				5'd23: v = 36'sd127;
				5'd24: v = 36'sd63;
				5'd25: v = 36'sd31;
				5'd26: v = 36'sd15;
				5'd27: v = 36'sd8;
				5'd28: v = 36'sd4;
				5'd29: v = 36'sd2;
				default: v = 36'sd0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ design/dead_reckoning_pose_update_core.sv @@
// Top level: pose registers, sequencer, shared product register and config registers.
//
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, mode ... load_heading  | into block
//  out     | out_valid/out_ready, pos_x pos_y heading  | out of block
//  cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// A load word is written to the pose registers and goes straight to the
// result. A move word reduces the heading (up to 3 heading subtractions),
// then runs the CORDIC, the two products and the bit-serial remainder unit,
// run once for x and once for y. Reset clears the pose to zero and the
// map size to 65536000. in_ready is high only while idle; a stalled result
// holds the block.
`timescale 1ns / 1ps
module dead_reckoning_pose_update_core #(
	parameter int CORDIC_STEPS = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic signed [19:0]  turn_angle,
	input  logic signed [30:0]  forward_dist,
	input  logic signed [19:0]  turn_noise_sample,
	input  logic signed [30:0]  forward_noise_sample,
	input  logic signed [31:0]  load_x,
	input  logic signed [31:0]  load_y,
	input  logic signed [19:0]  load_heading,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  pos_x,
	output logic signed [31:0]  pos_y,
	output logic signed [19:0]  heading,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [30:0]         cfg_data
);
	import drpu_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HMOD, ST_CORD, ST_MULC, ST_MULS, ST_RND,
		ST_DIVX, ST_DIVY, ST_OUT
	} state_t;

	state_t state_q;
	logic [30:0] map_w_q, map_h_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic signed [19:0] pose_h_q;
	logic [21:0] hmag_q;
	logic hneg_q;
	logic signed [31:0] dist_q;
	logic signed [63:0] prod_q;
	logic signed [33:0] dx_q, dy_q;
	logic cord_start_q, rem_start_q;
	logic signed [34:0] rem_val_q;
	logic [30:0] rem_mod_q;

	logic cord_done, rem_done;
	logic signed [31:0] cos_v, sin_v, rem_res;
	logic signed [21:0] hsum;
	logic signed [63:0] rnd;
	logic signed [19:0] hred;

	always_comb begin
		hsum = 22'(pose_h_q) + 22'(turn_angle) + 22'(turn_noise_sample);
		rnd = (prod_q + ROUND_Q30) >>> 30;
		hred = hneg_q ? -hmag_q[19:0] : hmag_q[19:0];
	end

	drpu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start_q), .angle(pose_h_q),
		.done(cord_done), .cos_val(cos_v), .sin_val(sin_v)
	);

	drpu_rem u_rem (
		.clk(clk), .arst_n(arst_n), .start(rem_start_q), .value(rem_val_q),
		.modulus(rem_mod_q), .done(rem_done), .result(rem_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q <= 31'd65536000;
			map_h_q <= 31'd65536000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAP_WIDTH:  map_w_q <= cfg_data;
				REG_MAP_HEIGHT: map_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			cord_start_q <= 1'b0;
			rem_start_q <= 1'b0;
		end else begin
			cord_start_q <= 1'b0;
			rem_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (mode) begin
							pose_x_q <= load_x;
							pose_y_q <= load_y;
							pose_h_q <= load_heading;
							state_q <= ST_OUT;
						end else begin
							hneg_q <= hsum[21];
							hmag_q <= hsum[21] ? -hsum : hsum;
							dist_q <= 32'(forward_dist) + 32'(forward_noise_sample);
							state_q <= ST_HMOD;
						end
					end
				end
				ST_HMOD: begin
					if (hmag_q >= TWO_PI_Q16) begin
						hmag_q <= hmag_q - TWO_PI_Q16;
					end else begin
						pose_h_q <= hred;
						cord_start_q <= 1'b1;
						state_q <= ST_CORD;
					end
				end
				ST_CORD: begin
					if (cord_done) begin
						state_q <= ST_MULC;
					end
				end
				ST_MULC: begin
					prod_q <= dist_q * cos_v;
					state_q <= ST_MULS;
				end
				ST_MULS: begin
					dx_q <= rnd[33:0];
					prod_q <= dist_q * sin_v;
					state_q <= ST_RND;
				end
				ST_RND: begin
					dy_q <= rnd[33:0];
					rem_val_q <= 35'(pose_x_q) + 35'(dx_q);
					rem_mod_q <= map_w_q;
					rem_start_q <= 1'b1;
					state_q <= ST_DIVX;
				end
				ST_DIVX: begin
					if (rem_done) begin
						pose_x_q <= rem_res;
						rem_val_q <= 35'(pose_y_q) + 35'(dy_q);
						rem_mod_q <= map_h_q;
						rem_start_q <= 1'b1;
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (rem_done) begin
						pose_y_q <= rem_res;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign pos_x = pose_x_q;
	assign pos_y = pose_y_q;
	assign heading = pose_h_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_cord_done: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> state_q == ST_CORD) else $error("stray cordic done");
	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		rem_done |-> (state_q == ST_DIVX || state_q == ST_DIVY))
		else $error("stray remainder done");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y))
		else $error("result changed while stalled");

endmodule

@@ design/drpu_cordic.sv @@
// Iterative CORDIC rotation unit: cos and sin of a Q3.16 heading.
`timescale 1ns / 1ps
module drpu_cordic #(
	parameter int STEPS = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [19:0]  angle,
	output logic                done,
	output logic signed [31:0]  cos_val,
	output logic signed [31:0]  sin_val
);
	import drpu_pkg::*;

	localparam int N = (STEPS > MAX_STEPS) ? MAX_STEPS : STEPS;
	localparam logic [STEP_W-1:0] LAST = STEP_W'(N - 1);

	logic signed [33:0] x_q, y_q;
	logic signed [35:0] z_q;
	logic [STEP_W-1:0] i_q;
	logic neg_q, busy_q, done_q;

	logic signed [35:0] z0, z1, z2;
	logic neg0;
	logic signed [33:0] xs, ys;

	always_comb begin
		z0 = {{2{angle[19]}}, angle, 14'b0};
		if (z0 > PI_Q30) begin
			z1 = z0 - TWO_PI_Q30;
		end else if (z0 < -PI_Q30) begin
			z1 = z0 + TWO_PI_Q30;
		end else begin
			z1 = z0;
		end
		neg0 = 1'b0;
		z2 = z1;
		if (z1 > HALF_PI_Q30) begin
			z2 = z1 - PI_Q30;
			neg0 = 1'b1;
		end else if (z1 < -HALF_PI_Q30) begin
			z2 = z1 + PI_Q30;
			neg0 = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= GAIN_Q30;
			y_q <= '0;
			z_q <= z2;
			neg_q <= neg0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q30(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q30(i_q);
			end
		end
	end

	assign done = done_q;
	assign cos_val = neg_q ? -x_q[31:0] : x_q[31:0];
	assign sin_val = neg_q ? -y_q[31:0] : y_q[31:0];

endmodule

@@ design/drpu_rem.sv @@
// Bit-serial truncated remainder of a signed 35-bit value by an unsigned modulus.
`timescale 1ns / 1ps
module drpu_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [34:0]  value,
	input  logic [30:0]         modulus,
	output logic                done,
	output logic signed [31:0]  result
);
	import drpu_pkg::*;

	localparam int MAG_W = 34;
	localparam logic [5:0] LAST = 6'(MAG_W - 1);

	logic [MAG_W-1:0] mag_q;
	logic [32:0] rem_q;
	logic [30:0] m_q;
	logic [5:0] cnt_q;
	logic neg_q, busy_q, done_q;
	logic signed [31:0] res_q;

	logic signed [34:0] absv;
	logic [32:0] trial, nrem;

	always_comb begin
		absv = value[34] ? -value : value;
		trial = {rem_q[31:0], mag_q[MAG_W-1]};
		nrem = (trial >= {2'b0, m_q}) ? trial - {2'b0, m_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (modulus == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= absv[MAG_W-1:0];
			rem_q <= '0;
			m_q <= modulus;
			neg_q <= value[34];
			res_q <= value[31:0];
		end else if (busy_q) begin
			mag_q <= mag_q << 1;
			rem_q <= nrem;
			if (cnt_q == LAST) begin
				res_q <= neg_q ? -nrem[31:0] : nrem[31:0];
			end
		end
	end

	assign done = done_q;
	assign result = res_q;

endmodule
